FILE: src/prun_pkg.sv
// shared constants, types and helpers for the page run allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package prun_pkg;

    localparam int PAGE_SLOTS    = 16384;
    localparam int ADDR_W        = $clog2(PAGE_SLOTS);
    localparam int LEN_W         = ADDR_W + 1;
    localparam int IDX_W         = LEN_W + 2;
    localparam int SKIP_LIMIT    = 63;
    localparam int SKIP_W        = 6;
    localparam int REPAIR_WINDOW = 64;
    localparam int ENTRY_W       = 8;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_ADD   = 2'd2;
    localparam logic [1:0] OP_MARK  = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_RUN   = 2'd1;
    localparam logic [1:0] STATUS_RANGE    = 2'd2;
    localparam logic [1:0] STATUS_ZERO_LEN = 2'd3;

    // entry bits 7:6
    localparam logic [1:0] PS_EXTERNAL    = 2'b00;
    localparam logic [1:0] PS_ALLOCATED   = 2'b01;
    localparam logic [1:0] PS_FREE_DIRTY  = 2'b10;
    localparam logic [1:0] PS_FREE_ZEROED = 2'b11;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [ENTRY_W-1:0]    wdata;
        logic [ADDR_W-1:0]     raddr;
    } t_ram_req;

    function automatic logic [SKIP_W-1:0] clamp_skip(input logic [LEN_W-1:0] v);
        logic [SKIP_W-1:0] r;
        if (v > LEN_W'(SKIP_LIMIT)) begin
            r = SKIP_W'(SKIP_LIMIT);
        end else begin
            r = v[SKIP_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/prun_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module prun_ram #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: src/prun_ctrl.sv
// sequencer: walks the page table through the ram, one entry per step
// depends on prun_pkg
`timescale 1ns / 1ps
`default_nettype none

module prun_ctrl import prun_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [ADDR_W-1:0]    i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_opcode,
    input  wire logic [ADDR_W-1:0]    i_start_page,
    input  wire logic [LEN_W-1:0]     i_run_length,
    input  wire logic                 i_zero_request,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic      [1:0]           o_status,
    output logic      [ADDR_W-1:0]    o_granted_page,
    output logic      [LEN_W-1:0]     o_dirty_count,
    output t_ram_req                  o_ram,
    input  wire logic [ENTRY_W-1:0]   i_rdata
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_LOOP, S_HEAD, S_RUN_RD, S_RUN,
        S_AL_RD, S_AL_WR, S_FREE_RD, S_FREE_WR, S_REP_RD, S_REP_WR,
        S_FILL, S_DONE
    } t_state;

    t_state              r_state;
    logic [ADDR_W-1:0]   r_clr;
    logic [ADDR_W-1:0]   r_scan_start;
    logic [ADDR_W-1:0]   r_scan_end;
    logic [1:0]          r_op;
    logic [ADDR_W-1:0]   r_start;
    logic [LEN_W-1:0]    r_len;
    logic                r_zr;
    logic [IDX_W-1:0]    r_i;
    logic [LEN_W-1:0]    r_k;
    logic [LEN_W-1:0]    r_cnt;
    logic [1:0]          r_status;

    logic [IDX_W-1:0]    n_run_last;
    logic [IDX_W-1:0]    n_run_addr;
    logic [LEN_W-1:0]    n_remain;
    logic [LEN_W-1:0]    n_range_end;
    logic [ADDR_W-1:0]   n_lim_dist;
    logic [SKIP_W-1:0]   n_lim;
    logic [SKIP_W-1:0]   n_skip;
    logic [1:0]          n_fill_state;

    assign n_skip      = i_rdata[SKIP_W-1:0];
    assign n_run_last  = r_i + IDX_W'(r_len) - IDX_W'(1);
    assign n_run_addr  = r_i + IDX_W'(r_k);
    assign n_remain    = r_len - LEN_W'(1) - r_k;
    assign n_range_end = LEN_W'(r_start) + r_k;
    assign n_lim_dist  = r_start - r_i[ADDR_W-1:0] - ADDR_W'(1);
    assign n_lim       = clamp_skip(LEN_W'(n_lim_dist));
    assign n_fill_state = (r_op == OP_ADD) ? PS_FREE_ZEROED : PS_EXTERNAL;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        o_ram       = '0;
        o_ram.raddr = n_run_addr[ADDR_W-1:0];
        case (r_state)
            S_CLEAR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_clr;
            end
            S_AL_WR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = n_run_addr[ADDR_W-1:0];
                o_ram.wdata = {PS_ALLOCATED, clamp_skip(n_remain)};
            end
            S_FREE_RD: o_ram.raddr = n_range_end[ADDR_W-1:0];
            S_FREE_WR: begin
                o_ram.we    = (i_rdata[7:6] == PS_ALLOCATED);
                o_ram.waddr = n_range_end[ADDR_W-1:0];
                o_ram.wdata = {PS_FREE_DIRTY, SKIP_W'(0)};
            end
            S_REP_RD: o_ram.raddr = r_i[ADDR_W-1:0];
            S_REP_WR: begin
                o_ram.we    = (n_skip > n_lim);
                o_ram.waddr = r_i[ADDR_W-1:0];
                o_ram.wdata = {i_rdata[7:6], n_lim};
            end
            S_FILL: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = n_range_end[ADDR_W-1:0];
                o_ram.wdata = {n_fill_state, clamp_skip(n_remain)};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_scan_start <= '0;
            r_scan_end   <= '0;
            o_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_scan_start <= i_cfg_data;
            end
            if (o_out_valid && !i_out_stall && r_state != S_DONE) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == ADDR_W'(PAGE_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_opcode;
                        r_start <= i_start_page;
                        r_len   <= i_run_length;
                        r_zr    <= i_zero_request;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_cnt    <= '0;
                    r_k      <= '0;
                    r_status <= STATUS_OK;
                    r_i      <= IDX_W'(r_scan_start);
                    if (r_len == '0) begin
                        r_status <= STATUS_ZERO_LEN;
                        r_state  <= S_DONE;
                    end else if (r_op == OP_ALLOC) begin
                        r_state <= S_LOOP;
                    end else if ((LEN_W+1)'(r_start) + (LEN_W+1)'(r_len)
                                 > (LEN_W+1)'(PAGE_SLOTS)) begin
                        r_status <= STATUS_RANGE;
                        r_state  <= S_DONE;
                    end else if (r_op == OP_FREE) begin
                        r_state <= S_FREE_RD;
                    end else begin
                        if (r_op == OP_ADD) begin
                            r_scan_end <= r_start + r_len[ADDR_W-1:0] - ADDR_W'(1);
                        end
                        r_state <= S_FILL;
                    end
                end
                S_LOOP: begin
                    // the run must end at or before scan_end; also covers i past the end
                    r_k <= '0;
                    if (n_run_last > IDX_W'(r_scan_end)) begin
                        r_status <= STATUS_NO_RUN;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    if (!i_rdata[7]) begin
                        r_i     <= r_i + IDX_W'(n_skip) + IDX_W'(1);
                        r_state <= S_LOOP;
                    end else begin
                        r_k     <= r_len - LEN_W'(1);
                        r_state <= S_RUN_RD;
                    end
                end
                S_RUN_RD: r_state <= S_RUN;
                S_RUN: begin
                    if (!i_rdata[7]) begin
                        r_i     <= n_run_addr + IDX_W'(n_skip) + IDX_W'(1);
                        r_k     <= '0;
                        r_state <= S_LOOP;
                    end else if (r_k == '0) begin
                        r_state <= S_AL_RD;
                    end else begin
                        r_k     <= r_k - LEN_W'(1);
                        r_state <= S_RUN_RD;
                    end
                end
                S_AL_RD: r_state <= S_AL_WR;
                S_AL_WR: begin
                    if (r_zr && !i_rdata[6]) begin
                        r_cnt <= r_cnt + LEN_W'(1);
                    end
                    if (n_remain == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k     <= r_k + LEN_W'(1);
                        r_state <= S_AL_RD;
                    end
                end
                S_FREE_RD: r_state <= S_FREE_WR;
                S_FREE_WR: begin
                    if (n_remain != '0) begin
                        r_k     <= r_k + LEN_W'(1);
                        r_state <= S_FREE_RD;
                    end else if (r_start == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        if (r_start > ADDR_W'(REPAIR_WINDOW)) begin
                            r_i <= IDX_W'(r_start - ADDR_W'(REPAIR_WINDOW));
                        end else begin
                            r_i <= '0;
                        end
                        r_state <= S_REP_RD;
                    end
                end
                S_REP_RD: r_state <= S_REP_WR;
                S_REP_WR: begin
                    if (n_lim_dist == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_i     <= r_i + IDX_W'(1);
                        r_state <= S_REP_RD;
                    end
                end
                S_FILL: begin
                    if (n_remain == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k <= r_k + LEN_W'(1);
                    end
                end
                S_DONE: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_valid <= 1'b1;
                        o_status    <= r_status;
                        o_dirty_count <= r_cnt;
                        if (r_op == OP_ALLOC && r_status == STATUS_OK) begin
                            o_granted_page <= r_i[ADDR_W-1:0];
                        end else begin
                            o_granted_page <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/page_run_allocator_core.sv
// top level of the page run allocator: page table ram plus sequencer
// depends on prun_pkg, prun_ram, prun_ctrl
`timescale 1ns / 1ps
`default_nettype none

// First-fit page allocator over a 16384-entry page table held in one
// synchronous ram. After reset a clearing pass writes every entry to external;
// no transaction is accepted until it ends, scan_start writes are taken at
// any time. One request is worked at a time: alloc reads each entry probed
// by the search, then reads and writes back each granted page; free reads
// and writes back each page of the range, then each repaired entry (up to
// 64); add and mark write each page once. A page is read and then written
// back because the ram's read is registered. A finished result waits in the
// output register while the next request is accepted.
module page_run_allocator_core import prun_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [ADDR_W-1:0]    i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_opcode,
    input  wire logic [ADDR_W-1:0]    i_start_page,
    input  wire logic [LEN_W-1:0]     i_run_length,
    input  wire logic                 i_zero_request,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic      [1:0]           o_status,
    output logic      [ADDR_W-1:0]    o_granted_page,
    output logic      [LEN_W-1:0]     o_dirty_count
);

    t_ram_req           ram_req;
    logic [ENTRY_W-1:0] ram_rdata;

    prun_ram #(
        .DEPTH (PAGE_SLOTS),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    prun_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_start_page   (i_start_page),
        .i_run_length   (i_run_length),
        .i_zero_request (i_zero_request),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_granted_page (o_granted_page),
        .o_dirty_count  (o_dirty_count),
        .o_ram          (ram_req),
        .i_rdata        (ram_rdata)
    );

    // an accepted transaction keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted twice in a row");

    // failed requests carry no page and no dirty count
    a_fail_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != STATUS_OK) |->
            (o_granted_page == '0 && o_dirty_count == '0))
        else $error("payload on failed request");

    // a zero-length result never reports dirty pages
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STATUS_ZERO_LEN) |-> (o_dirty_count == '0))
        else $error("dirty count on zero-length request");

endmodule

`default_nettype wire
